### src/float_to_half_convert_top_defines.svh
// Assertion macros for the converter's top-level RTL file.
// Depends on nothing; files that use them provide clock and reset signals.
`ifndef FLOAT_TO_HALF_CONVERT_TOP_DEFINES_SVH
`define FLOAT_TO_HALF_CONVERT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FTHC_CHECK(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fthc check failed");

// Next-cycle implication, checked outside reset.
`define FTHC_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fthc check failed");

`endif

### src/fthc_pkg.sv
// Package for the single-to-half converter: widths, exponent limits, stage types.
// Depends on nothing.
package fthc_pkg;

   localparam int SINGLE_W = 32;
   localparam int HALF_W   = 16;
   localparam int SGL_EW   = 8;
   localparam int HLF_EW   = 5;
   localparam int HLF_MW   = 10;
   localparam int MANT_W   = HLF_MW + 1;   // kept mantissa bits plus round bit
   localparam int SHIFT_W  = 4;

   localparam int SGL_BIAS    = 127;
   localparam int HLF_BIAS    = 15;
   localparam int HLF_EXP_MAX = 31;
   localparam int REBIAS      = SGL_BIAS - HLF_BIAS;

   localparam logic [SGL_EW-1:0] SGL_EXP_ALL  = 8'hFF;
   localparam logic [SGL_EW-1:0] SGL_EXP_OVF  = SGL_EW'(REBIAS + HLF_EXP_MAX);
   localparam logic [SGL_EW-1:0] SGL_EXP_SUB  = SGL_EW'(REBIAS);
   localparam logic [SGL_EW-1:0] SGL_EXP_LOST = SGL_EW'(REBIAS - HLF_MW);

   localparam logic [HALF_W-2:0] HALF_INF_MAG = 15'h7C00;
   localparam logic [HALF_W-1:0] HALF_NAN     = 16'hFE00;

   typedef enum logic [1:0] {
      KIND_FIXED,
      KIND_SUB,
      KIND_NORM
   } kind_type;

   // Decode stage result.
   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic                sign;
      logic [HLF_EW-1:0]   exp5;
      logic [MANT_W-1:0]   mant;
      logic [SHIFT_W-1:0]  shift;
      logic [HALF_W-1:0]   fixed;
   } dec_type;

   // Align stage result: unrounded pattern plus round bit.
   typedef struct packed {
      logic                valid;
      logic [HALF_W-1:0]   base;
      logic                rnd;
   } aln_type;

endpackage

### src/fthc_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on fthc_pkg.
interface fthc_req_if;
   logic                          valid;
   logic                          ready;
   logic [fthc_pkg::SINGLE_W-1:0] single_bits;

   modport source (output valid, output single_bits, input ready);
   modport sink   (input valid, input single_bits, output ready);
endinterface

interface fthc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fthc_pkg::HALF_W-1:0] half_bits;

   modport source (output valid, output half_bits, input ready);
   modport sink   (input valid, input half_bits, output ready);
endinterface

### src/fthc_decode.sv
// First stage: classify the binary32 pattern and rebias its exponent.
// Depends on fthc_pkg.
module fthc_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [fthc_pkg::SINGLE_W-1:0] single_bits,
   output logic                          in_ready,
   output fthc_pkg::dec_type             dec_ff,
   input  logic                          out_ready
);
   import fthc_pkg::*;

   dec_type             dec_in;
   logic                sign;
   logic [SGL_EW-1:0]   expf;
   logic [22:0]         man;

   assign sign = single_bits[31];
   assign expf = single_bits[30:23];
   assign man  = single_bits[22:0];

   assign in_ready = !dec_ff.valid || out_ready;

   always_comb begin
      dec_in       = '0;
      dec_in.valid = in_valid;
      dec_in.kind  = KIND_FIXED;
      dec_in.sign  = sign;
      dec_in.fixed = {sign, 15'd0};
      if (expf == '0) begin
         // zero and single denormals: signed zero
         dec_in.fixed = {sign, 15'd0};
      end else if (expf == SGL_EXP_ALL) begin
         dec_in.fixed = (man == '0) ? {sign, HALF_INF_MAG} : HALF_NAN;
      end else if (expf >= SGL_EXP_OVF) begin
         dec_in.fixed = {sign, HALF_INF_MAG};
      end else if (expf <= SGL_EXP_SUB) begin
         if (expf >= SGL_EXP_LOST) begin
            // hidden bit and top mantissa bits, shifted right later
            dec_in.kind  = KIND_SUB;
            dec_in.mant  = {1'b1, man[22:13]};
            dec_in.shift = SHIFT_W'(SGL_EXP_SUB - expf);
         end
      end else begin
         dec_in.kind = KIND_NORM;
         dec_in.exp5 = HLF_EW'(expf - SGL_EXP_SUB);
         dec_in.mant = man[22:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else if (in_ready) begin
         dec_ff <= dec_in;
      end
   end

endmodule

### src/fthc_align.sv
// Second stage: denormal right shift and assembly of the unrounded pattern.
// Depends on fthc_pkg.
module fthc_align (
   input  logic              clock,
   input  logic              reset,
   input  fthc_pkg::dec_type dec,
   output logic              in_ready,
   output fthc_pkg::aln_type aln_ff,
   input  logic              out_ready
);
   import fthc_pkg::*;

   aln_type           aln_in;
   logic [MANT_W-1:0] shifted;

   assign in_ready = !aln_ff.valid || out_ready;
   assign shifted  = dec.mant >> dec.shift;

   always_comb begin
      aln_in       = '0;
      aln_in.valid = dec.valid;
      case (dec.kind)
         KIND_SUB: begin
            aln_in.base = {dec.sign, {HLF_EW{1'b0}}, shifted[MANT_W-1:1]};
            aln_in.rnd  = shifted[0];
         end
         KIND_NORM: begin
            aln_in.base = {dec.sign, dec.exp5, dec.mant[MANT_W-1:1]};
            aln_in.rnd  = dec.mant[0];
         end
         default: begin
            aln_in.base = dec.fixed;
            aln_in.rnd  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aln_ff.valid <= 1'b0;
      end else if (in_ready) begin
         aln_ff <= aln_in;
      end
   end

endmodule

### src/fthc_round.sv
// Third stage: round half away from zero and hold the result item for the response channel.
// Depends on fthc_pkg.
module fthc_round (
   input  logic                        clock,
   input  logic                        reset,
   input  fthc_pkg::aln_type           aln,
   output logic                        in_ready,
   output logic                        out_valid,
   output logic [fthc_pkg::HALF_W-1:0] out_half,
   input  logic                        out_ready
);
   import fthc_pkg::*;

   logic              valid_ff;
   logic [HALF_W-1:0] half_ff;
   logic [HALF_W-1:0] half_in;

   assign in_ready = !valid_ff || out_ready;
   // carry may run into the exponent, up to infinity
   assign half_in  = aln.base + {{(HALF_W-1){1'b0}}, aln.rnd};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= aln.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         half_ff <= half_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_half  = half_ff;

endmodule

### src/float_to_half_convert_top.sv
// Single-to-half converter top level: three register stages (decode, align, round).
// Throughput: one item per cycle while the response channel is not stalled.
// Each stage advances when the next is empty or moving; a stalled response holds
// the full stages up to the first empty one. No item is lost or repeated.
// Reset (synchronous, active high) clears the stage valid bits only.
// Depends on fthc_pkg, the channel interfaces, the stage modules and the macro header.
`include "float_to_half_convert_top_defines.svh"

module float_to_half_convert_top (
   input  logic         clock,
   input  logic         reset,
   fthc_req_if.sink     req_chan,
   fthc_rsp_if.source   rsp_chan
);
   import fthc_pkg::*;

   dec_type dec;
   aln_type aln;
   logic    align_ready;
   logic    round_ready;

   // Decode: classify the pattern, pick a fixed result or rebias the exponent.
   fthc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .single_bits (req_chan.single_bits),
      .in_ready    (req_chan.ready),
      .dec_ff      (dec),
      .out_ready   (align_ready)
   );

   // Align: shift denormal mantissas, assemble sign, exponent and mantissa.
   fthc_align u_align (
      .clock     (clock),
      .reset     (reset),
      .dec       (dec),
      .in_ready  (align_ready),
      .aln_ff    (aln),
      .out_ready (round_ready)
   );

   // Round: add the first discarded bit and hold the result for the sink.
   fthc_round u_round (
      .clock     (clock),
      .reset     (reset),
      .aln       (aln),
      .in_ready  (round_ready),
      .out_valid (rsp_chan.valid),
      .out_half  (rsp_chan.half_bits),
      .out_ready (rsp_chan.ready)
   );

   // Hold the decode stage while the align stage is blocked.
   `FTHC_CHECK_NEXT(a_dec_hold, dec.valid && !align_ready, $stable(dec))
   // Hold the align stage while the round stage is blocked.
   `FTHC_CHECK_NEXT(a_aln_hold, aln.valid && !round_ready, $stable(aln))
   // Back-pressure at the input only when every stage holds an item.
   `FTHC_CHECK(a_full_stall, !req_chan.ready, dec.valid && aln.valid && rsp_chan.valid)
   // Any NaN result is the canonical quiet pattern.
   `FTHC_CHECK(a_nan_canon,
      rsp_chan.valid && rsp_chan.half_bits[14:10] == 5'h1F && rsp_chan.half_bits[9:0] != 10'd0,
      rsp_chan.half_bits == HALF_NAN)

endmodule
